// File: hdl/spq_pkg.sv
`timescale 1ns / 1ps
package spq_pkg;

	// fixed field widths of the transaction payloads and the default queue depth
	localparam int KEY_W = 32;
	localparam int CNT_OUT_W = 5;
	localparam int DEPTH_DEF = 16;

	typedef enum logic {
		FUNC_PUSH = 1'b0,
		FUNC_POP  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		func_t                    func;
		logic signed [KEY_W-1:0]  key_in;
	} in_item_t;

	typedef struct packed {
		logic signed [KEY_W-1:0]  popped_key;
		logic signed [KEY_W-1:0]  top_key;
		logic [CNT_OUT_W-1:0]     entry_count;
		status_t                  status;
	} out_item_t;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic                     push;
		logic                     pop;
		logic signed [KEY_W-1:0]  key;
	} cell_ctl_t;

endpackage

// File: hdl/spq_cell.sv
`timescale 1ns / 1ps
module spq_cell (
	input  logic                              clk,
	input  spq_pkg::cell_ctl_t                ctl,
	input  logic                              occupied,
	input  logic                              prev_stay,
	input  logic signed [spq_pkg::KEY_W-1:0]  prev_key,
	input  logic signed [spq_pkg::KEY_W-1:0]  next_key,
	output logic                              stay,
	output logic signed [spq_pkg::KEY_W-1:0]  key,
	output logic signed [spq_pkg::KEY_W-1:0]  key_d
);
	import spq_pkg::*;

	logic signed [KEY_W-1:0] key_q;

	// keys are held largest first: a stored key larger than the new one keeps its place
	assign stay = occupied && (key_q > ctl.key);

	// next key: shift toward the head on pop, open a slot on push
	always_comb begin
		key_d = key_q;
		if (ctl.pop) begin
			key_d = next_key;
		end else if (ctl.push) begin
			if (stay) begin
				key_d = key_q;
			end else if (prev_stay) begin
				key_d = ctl.key;
			end else begin
				key_d = prev_key;
			end
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
	end

	assign key = key_q;

endmodule

// File: hdl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// result: a transaction's result is registered and shown in the cycle after it is accepted
// throughput: one push or pop per cycle while the result side does not stall;
//   each cycle every cell of the chain takes its new key from itself, a neighbor or the pushed key
// reset: arst_n clears the entry count and the output valid; stored keys are not
//   cleared and are read only below the entry count
module sorted_priority_queue #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  spq_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output spq_pkg::out_item_t out_item
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic                    accept;
	logic                    full;
	logic                    empty;
	cell_ctl_t               ctl;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_d;
	logic                    out_valid_q;
	out_item_t               out_item_q;
	out_item_t               result;
	logic [DEPTH-1:0]        occupied;
	logic [DEPTH-1:0]        stay;
	logic signed [KEY_W-1:0] cell_key [DEPTH];
	logic signed [KEY_W-1:0] cell_key_d [DEPTH];

	// input handshake: take a transaction unless the held result is stalled
	assign in_stall = out_valid_q && out_stall;
	assign accept = in_valid && !in_stall;
	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	// command for the cell chain
	always_comb begin
		ctl.key = in_item.key_in;
		ctl.push = accept && (in_item.func == FUNC_PUSH) && !full;
		ctl.pop = accept && (in_item.func == FUNC_POP) && !empty;
	end

	// cell chain, head holds the largest key
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                    prev_stay;
		logic signed [KEY_W-1:0] prev_key;
		logic signed [KEY_W-1:0] next_key;

		assign occupied[i] = (count_q > CNT_W'(i));

		// nothing sits ahead of the head, so on a push it takes the new key unless it keeps its own
		if (i == 0) begin : g_head
			assign prev_stay = 1'b1;
			assign prev_key = '0;
		end else begin : g_body
			assign prev_stay = stay[i-1];
			assign prev_key = cell_key[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_key = cell_key[i];
		end else begin : g_link
			assign next_key = cell_key[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (occupied[i]),
			.prev_stay (prev_stay),
			.prev_key  (prev_key),
			.next_key  (next_key),
			.stay      (stay[i]),
			.key       (cell_key[i]),
			.key_d     (cell_key_d[i])
		);
	end

	// next count and result of the accepted transaction
	always_comb begin
		count_d = count_q;
		if (ctl.push) begin
			count_d = count_q + CNT_W'(1);
		end else if (ctl.pop) begin
			count_d = count_q - CNT_W'(1);
		end

		result.popped_key = ctl.pop ? cell_key[0] : '0;
		result.top_key = (count_d != '0) ? cell_key_d[0] : '0;
		result.entry_count = CNT_OUT_W'(count_d);
		result.status = ST_OK;
		if (in_item.func == FUNC_POP) begin
			if (empty) begin
				result.status = ST_EMPTY;
			end
		end else if (full) begin
			result.status = ST_FULL;
		end
	end

	// entry count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (accept) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

endmodule

// File: hdl/spq_checker.sv
`timescale 1ns / 1ps
module spq_checker #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input spq_pkg::out_item_t out_item
);
	import spq_pkg::*;

	// a pop on an empty queue reports an empty queue
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status == ST_EMPTY) |->
			(out_item.entry_count == '0) && (out_item.top_key == '0) &&
			(out_item.popped_key == '0))
		else $error("empty pop result not clean");

	// a refused push removes nothing and reports a full queue
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status == ST_FULL) |->
			(out_item.popped_key == '0) &&
			(out_item.entry_count == CNT_OUT_W'(DEPTH)))
		else $error("full push result wrong");

	// an empty queue shows no top key
	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.entry_count == '0) |-> (out_item.top_key == '0))
		else $error("top key shown on empty queue");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	// input stalls only behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a waiting result");

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
